@@ sv/tshl_pkg.sv @@
// shared types and constants for the tiger syntax highlight lexer
package tshl_pkg;

   localparam int MAX_LINE = 4096;
   localparam int LEN_W = 13;
   localparam int MAX_RES = 4;
   localparam int PREFIX_DEPTH = 9;

   typedef enum logic [2:0] {
      ST_PLAIN    = 3'd0,
      ST_COMMENT  = 3'd1,
      ST_STRING   = 3'd2,
      ST_NUMBER   = 3'd3,
      ST_KEYWORD  = 3'd4,
      ST_TYPE     = 3'd5,
      ST_FUNCTION = 3'd6
   } style_type;

   typedef enum logic [3:0] {
      PH_NORMAL        = 4'd0,
      PH_SLASH         = 4'd1,
      PH_IDENT         = 4'd2,
      PH_IDENT_LONG    = 4'd3,
      PH_SPACES        = 4'd4,
      PH_COMMENT       = 4'd5,
      PH_COMMENT_STAR  = 4'd6,
      PH_COMMENT_SLASH = 4'd7,
      PH_STR           = 4'd8,
      PH_STR_ESC       = 4'd9,
      PH_STR_GAP       = 4'd10
   } phase_type;

   typedef logic [0:PREFIX_DEPTH-1][7:0] prefix_type;

   typedef struct packed {
      logic [3:0]       depth;
      logic             in_string;
      logic             in_gap;
      phase_type        phase;
      prefix_type       prefix;
      logic [LEN_W-1:0] ident_len;
      logic [LEN_W-1:0] spaces;
      logic [LEN_W-1:0] run_count;
      style_type        run_style;
   } state_type;

   typedef struct packed {
      style_type        style;
      logic [LEN_W-1:0] run_length;
      logic [5:0]       line_end_state;
      logic             last;
   } result_type;

   typedef struct packed {
      state_type                  st;
      result_type [MAX_RES-1:0]   res;
      logic [2:0]                 n;
   } work_type;

endpackage

@@ sv/tshl_step.sv @@
// next-state and run emission logic for one character or line-end transaction
module tshl_step (
   input  tshl_pkg::state_type state_cur,
   input  logic                cmd,
   input  logic [20:0]         ch,
   output tshl_pkg::work_type  work_nxt
);
   import tshl_pkg::*;

   localparam logic [20:0] CH_SLASH  = 21'h2F;
   localparam logic [20:0] CH_STAR   = 21'h2A;
   localparam logic [20:0] CH_QUOTE  = 21'h22;
   localparam logic [20:0] CH_BSLASH = 21'h5C;
   localparam logic [20:0] CH_SPACE  = 21'h20;
   localparam logic [20:0] CH_LPAREN = 21'h28;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);

   function automatic logic is_digit(logic [20:0] c);
      return c >= 21'h30 && c <= 21'h39;
   endfunction

   function automatic logic is_letter(logic [20:0] c);
      return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A);
   endfunction

   function automatic logic is_ident(logic [20:0] c);
      return is_letter(c) || is_digit(c) || c == 21'h5F;
   endfunction

   function automatic logic is_space(logic [20:0] c);
      return c == CH_SPACE || (c >= 21'd9 && c <= 21'd13);
   endfunction

   function automatic logic is_keyword(prefix_type p);
      return p == {"array", 32'd0} || p == {"break", 32'd0} || p == {"do", 56'd0} ||
             p == {"else", 40'd0} || p == {"end", 48'd0} || p == {"for", 48'd0} ||
             p == {"function", 8'd0} || p == {"if", 56'd0} || p == {"in", 56'd0} ||
             p == {"let", 48'd0} || p == {"nil", 48'd0} || p == {"of", 56'd0} ||
             p == {"then", 40'd0} || p == {"to", 56'd0} || p == {"type", 40'd0} ||
             p == {"var", 48'd0} || p == {"while", 32'd0};
   endfunction

   function automatic logic is_typename(prefix_type p);
      return p == {"int", 48'd0} || p == {"string", 24'd0};
   endfunction

   function automatic style_type word_class(state_type s);
      style_type r;
      r = ST_PLAIN;
      if (s.phase == PH_IDENT) begin
         if (is_keyword(s.prefix)) r = ST_KEYWORD;
         else if (is_typename(s.prefix)) r = ST_TYPE;
      end
      return r;
   endfunction

   function automatic work_type push(work_type w, style_type s, logic [LEN_W-1:0] len,
                                     logic [5:0] les, logic last);
      work_type r;
      r = w;
      if (r.n < 3'(MAX_RES)) begin
         r.res[r.n[1:0]] = '{style: s, run_length: len, line_end_state: les, last: last};
         r.n = r.n + 3'd1;
      end
      return r;
   endfunction

   // append n characters of one style to the held run, closing full or changed runs
   function automatic work_type emit(work_type w, style_type s, logic [LEN_W-1:0] n);
      work_type r;
      logic [LEN_W:0] tot;
      r = w;
      if (n != '0) begin
         if (r.st.run_count != '0 && (r.st.run_style != s || r.st.run_count >= MAX_LEN)) begin
            r = push(r, r.st.run_style, r.st.run_count, 6'd0, 1'b0);
            r.st.run_count = '0;
         end
         if (r.st.run_count == '0) r.st.run_style = s;
         tot = {1'b0, r.st.run_count} + {1'b0, n};
         if (tot > {1'b0, MAX_LEN}) begin
            r = push(r, s, MAX_LEN, 6'd0, 1'b0);
            r.st.run_count = LEN_W'(tot - {1'b0, MAX_LEN});
         end else begin
            r.st.run_count = tot[LEN_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic work_type normal_char(work_type w, logic [20:0] c);
      work_type r;
      r = w;
      r.st.phase = PH_NORMAL;
      if (c == CH_SLASH) begin
         r.st.phase = PH_SLASH;
      end else if (c == CH_QUOTE) begin
         r = emit(r, ST_STRING, LEN_W'(1));
         r.st.in_string = 1'b1;
         r.st.phase = PH_STR;
      end else if (is_digit(c)) begin
         r = emit(r, ST_NUMBER, LEN_W'(1));
      end else if (is_letter(c)) begin
         r.st.prefix = '0;
         r.st.prefix[0] = c[7:0];
         r.st.ident_len = LEN_W'(1);
         r.st.phase = PH_IDENT;
      end else begin
         r = emit(r, ST_PLAIN, LEN_W'(1));
      end
      return r;
   endfunction

   function automatic work_type comment_char(work_type w, logic [20:0] c);
      work_type r;
      phase_type ph;
      r = w;
      ph = w.st.phase;
      r = emit(r, ST_COMMENT, LEN_W'(1));
      if (ph == PH_COMMENT_STAR && c == CH_SLASH) begin
         r.st.depth = r.st.depth - 4'd1;
         r.st.phase = (r.st.depth == 4'd0) ? PH_NORMAL : PH_COMMENT;
      end else if (ph == PH_COMMENT_SLASH && c == CH_STAR) begin
         if (r.st.depth != 4'hF) r.st.depth = r.st.depth + 4'd1;
         r.st.phase = PH_COMMENT;
      end else if (c == CH_STAR) begin
         r.st.phase = PH_COMMENT_STAR;
      end else if (c == CH_SLASH) begin
         r.st.phase = PH_COMMENT_SLASH;
      end else begin
         r.st.phase = PH_COMMENT;
      end
      return r;
   endfunction

   function automatic work_type string_char(work_type w, logic [20:0] c);
      work_type r;
      logic done;
      r = w;
      done = 1'b0;
      if (r.st.phase == PH_STR_GAP) begin
         if (c == CH_SPACE) begin
            r = emit(r, ST_STRING, LEN_W'(1));
            done = 1'b1;
         end else begin
            r.st.in_gap = 1'b0;
            r.st.phase = PH_STR;
            if (c == CH_BSLASH) begin
               r = emit(r, ST_STRING, LEN_W'(1));
               done = 1'b1;
            end
         end
      end
      if (!done) begin
         r = emit(r, ST_STRING, LEN_W'(1));
         if (r.st.phase == PH_STR_ESC) begin
            if (c == CH_SPACE) begin
               r.st.in_gap = 1'b1;
               r.st.phase = PH_STR_GAP;
            end else begin
               r.st.phase = PH_STR;
            end
         end else if (c == CH_BSLASH) begin
            r.st.phase = PH_STR_ESC;
         end else if (c == CH_QUOTE) begin
            r.st.in_string = 1'b0;
            r.st.phase = PH_NORMAL;
         end
      end
      return r;
   endfunction

   function automatic work_type ident_char(work_type w, logic [20:0] c);
      work_type r;
      style_type cls;
      r = w;
      cls = word_class(w.st);
      if (is_ident(c)) begin
         if (r.st.ident_len >= MAX_LEN) begin
            r = emit(r, ST_PLAIN, r.st.ident_len);
            r.st.ident_len = LEN_W'(1);
            r.st.phase = PH_IDENT_LONG;
         end else begin
            if (r.st.ident_len < LEN_W'(PREFIX_DEPTH))
               r.st.prefix[r.st.ident_len[3:0]] = c[7:0];
            r.st.ident_len = r.st.ident_len + LEN_W'(1);
         end
      end else if (cls != ST_PLAIN) begin
         r = emit(r, cls, r.st.ident_len);
         r = normal_char(r, c);
      end else if (is_space(c)) begin
         r.st.spaces = LEN_W'(1);
         r.st.phase = PH_SPACES;
      end else begin
         r = emit(r, (c == CH_LPAREN) ? ST_FUNCTION : ST_PLAIN, r.st.ident_len);
         r = normal_char(r, c);
      end
      return r;
   endfunction

   function automatic work_type spaces_char(work_type w, logic [20:0] c);
      work_type r;
      r = w;
      if (is_space(c) && r.st.spaces < MAX_LEN) begin
         r.st.spaces = r.st.spaces + LEN_W'(1);
      end else begin
         r = emit(r, (c == CH_LPAREN) ? ST_FUNCTION : ST_PLAIN, r.st.ident_len);
         r = emit(r, ST_PLAIN, r.st.spaces);
         r.st.spaces = '0;
         r = normal_char(r, c);
      end
      return r;
   endfunction

   function automatic work_type end_line(work_type w);
      work_type r;
      logic [5:0] les;
      r = w;
      unique case (r.st.phase)
         PH_SLASH:                r = emit(r, ST_PLAIN, LEN_W'(1));
         PH_IDENT, PH_IDENT_LONG: r = emit(r, word_class(r.st), r.st.ident_len);
         PH_SPACES: begin
            r = emit(r, ST_PLAIN, r.st.ident_len);
            r = emit(r, ST_PLAIN, r.st.spaces);
         end
         PH_STR_ESC:              r.st.in_gap = 1'b1;
         default: ;
      endcase
      les = {r.st.in_gap, r.st.in_string, r.st.depth};
      r = push(r, (r.st.run_count != '0) ? r.st.run_style : ST_PLAIN, r.st.run_count,
               les, 1'b1);
      r.st.run_count = '0;
      r.st.run_style = ST_PLAIN;
      r.st.ident_len = '0;
      r.st.spaces = '0;
      if (r.st.depth != 4'd0) r.st.phase = PH_COMMENT;
      else if (r.st.in_gap) r.st.phase = PH_STR_GAP;
      else if (r.st.in_string) r.st.phase = PH_STR;
      else r.st.phase = PH_NORMAL;
      return r;
   endfunction

   always_comb begin
      work_type w;
      w.st = state_cur;
      w.res = '0;
      w.n = '0;
      if (cmd) begin
         w = end_line(w);
      end else begin
         unique case (state_cur.phase)
            PH_SLASH: begin
               if (ch == CH_STAR) begin
                  w = emit(w, ST_COMMENT, LEN_W'(2));
                  w.st.depth = 4'd1;
                  w.st.phase = PH_COMMENT;
               end else begin
                  w = emit(w, ST_PLAIN, LEN_W'(1));
                  w = normal_char(w, ch);
               end
            end
            PH_IDENT, PH_IDENT_LONG:                      w = ident_char(w, ch);
            PH_SPACES:                                    w = spaces_char(w, ch);
            PH_COMMENT, PH_COMMENT_STAR, PH_COMMENT_SLASH: w = comment_char(w, ch);
            PH_STR, PH_STR_ESC, PH_STR_GAP:               w = string_char(w, ch);
            default:                                      w = normal_char(w, ch);
         endcase
      end
      work_nxt = w;
   end

endmodule

@@ sv/tiger_syntax_highlight_lexer_core.sv @@
// top level of the tiger syntax highlight lexer: state register and result queue
//
// usage: feed the characters of a line on the req_ channel, one code point per
// transaction with req_tuser low, then one transaction with req_tuser high to
// mark the end of the line. the rsp_ channel returns style runs in text order;
// together they cover every character. the final run of a line carries
// rsp_tlast high and the line end state (comment depth, string and gap flags)
// that is carried into the next line.
// a character transaction is fully processed in the cycle it is accepted: the
// lexer state updates at that edge and its finished runs (zero to four) are
// written into an 8-entry result queue that feeds rsp_. throughput is one
// transaction per cycle while req_tready is high; runs are held until their
// style changes, so most characters produce no result. req_tready drops only
// while the queue has fewer than four free entries, which happens when the
// receiver stalls rsp_tready long enough to let results pile up.
// reset returns the lexer to the start of a line outside any comment or string
// and empties the queue.
module tiger_syntax_highlight_lexer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ch[20:0], zero pad
   input  logic [0:0]  req_tuser,   // cmd: 0 character, 1 end of line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // style[2:0], run_length[15:3], line_end_state[21:16], pad
   output logic        rsp_tlast
);
   import tshl_pkg::*;

   localparam int QDEPTH = 8;
   localparam int QA_W = $clog2(QDEPTH);

   state_type  state_ff, state_in;
   work_type   work;
   result_type queue_ff [QDEPTH];
   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QA_W:0]   count_ff, count_in;
   logic req_acc, rsp_acc;
   result_type head;

   tshl_step u_step (
      .state_cur (state_ff),
      .cmd       (req_tuser[0]),
      .ch        (req_tdata[20:0]),
      .work_nxt  (work)
   );

   // room for the worst case of four runs from one transaction
   assign req_tready = count_ff <= (QA_W+1)'(QDEPTH - MAX_RES);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {2'b00, head.line_end_state, head.run_length, head.style};
   assign rsp_tlast = head.last;

   always_comb begin
      state_in  = req_acc ? work.st : state_ff;
      wr_ptr_in = req_acc ? wr_ptr_ff + work.n : wr_ptr_ff;
      rd_ptr_in = rsp_acc ? rd_ptr_ff + QA_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (req_acc ? {1'b0, work.n} : '0)
                  - (rsp_acc ? (QA_W+1)'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, written at up to four consecutive slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RES; k++) begin
         if (req_acc && 3'(k) < work.n)
            queue_ff[QA_W'(wr_ptr_ff + QA_W'(k))] <= work.res[k];
      end
   end

endmodule

@@ tb/tiger_syntax_highlight_lexer_core_test.sv @@
// self-checking testbench for the tiger syntax highlight lexer core
`timescale 1ns / 1ps

module tiger_syntax_highlight_lexer_core_test;
   import tshl_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 320;

   typedef struct {
      bit          eol;
      logic [20:0] ch;
      bit          typed;
      result_type  want;
   } lex_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   tiger_syntax_highlight_lexer_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // lexer state mirrored by the predictor
   logic [3:0]  nest_depth;
   bit          in_str, in_gap;
   phase_type   phase;
   string       word;          // first identifier characters, at most PREFIX_DEPTH
   int          ident_len, space_cnt, held_cnt;
   style_type   held_style;
   int          runs_this_item;

   result_type  runs_due[$];
   lex_item_type stim[$];
   bit          failed = 1'b0;
   int          idle_pct = 0, stall_pct = 0;
   int          hold_left = 0;
   int          cycle_cnt = 0;

   string keywords[17] = '{"array", "break", "do", "else", "end", "for", "function", "if",
                           "in", "let", "nil", "of", "then", "to", "type", "var", "while"};
   string type_names[2] = '{"int", "string"};

   function automatic void push_run(style_type s, int n, logic [5:0] les, bit lst);
      if (runs_this_item < MAX_RES) begin
         runs_due.push_back('{style: s, run_length: n[LEN_W-1:0], line_end_state: les,
                              last: lst});
         runs_this_item++;
      end
   endfunction

   function automatic void add_chars(style_type s, int n);
      int take;
      while (n > 0) begin
         if (held_cnt > 0 && (held_style != s || held_cnt >= MAX_LINE)) begin
            push_run(held_style, held_cnt, 6'd0, 1'b0);
            held_cnt = 0;
         end
         if (held_cnt == 0) held_style = s;
         take = (n < MAX_LINE - held_cnt) ? n : MAX_LINE - held_cnt;
         held_cnt += take;
         n -= take;
      end
   endfunction

   function automatic bit is_digit(logic [20:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [20:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_space(logic [20:0] c);
      return c == " " || (c >= 9 && c <= 13);
   endfunction

   function automatic style_type word_style();
      if (phase != PH_IDENT || ident_len != word.len()) return ST_PLAIN;
      foreach (keywords[k]) if (keywords[k] == word) return ST_KEYWORD;
      foreach (type_names[k]) if (type_names[k] == word) return ST_TYPE;
      return ST_PLAIN;
   endfunction

   function automatic void plain_text_char(logic [20:0] c);
      phase = PH_NORMAL;
      if (c == "/") begin
         phase = PH_SLASH;
      end else if (c == "\"") begin
         add_chars(ST_STRING, 1);
         in_str = 1;
         phase = PH_STR;
      end else if (is_digit(c)) begin
         add_chars(ST_NUMBER, 1);
      end else if (is_letter(c)) begin
         word = " ";
         word.putc(0, c[7:0]);
         ident_len = 1;
         phase = PH_IDENT;
      end else begin
         add_chars(ST_PLAIN, 1);
      end
   endfunction

   function automatic void comment_text_char(logic [20:0] c);
      phase_type ph;
      ph = phase;
      add_chars(ST_COMMENT, 1);
      if (ph == PH_COMMENT_STAR && c == "/") begin
         nest_depth = nest_depth - 1;
         phase = (nest_depth == 0) ? PH_NORMAL : PH_COMMENT;
      end else if (ph == PH_COMMENT_SLASH && c == "*") begin
         if (nest_depth < 15) nest_depth++;
         phase = PH_COMMENT;
      end else if (c == "*") begin
         phase = PH_COMMENT_STAR;
      end else if (c == "/") begin
         phase = PH_COMMENT_SLASH;
      end else begin
         phase = PH_COMMENT;
      end
   endfunction

   function automatic void string_text_char(logic [20:0] c);
      if (phase == PH_STR_GAP) begin
         if (c == " ") begin
            add_chars(ST_STRING, 1);
            return;
         end
         in_gap = 0;
         phase = PH_STR;
         if (c == "\\") begin
            add_chars(ST_STRING, 1);
            return;
         end
      end
      add_chars(ST_STRING, 1);
      if (phase == PH_STR_ESC) begin
         if (c == " ") begin
            in_gap = 1;
            phase = PH_STR_GAP;
         end else begin
            phase = PH_STR;
         end
      end else if (c == "\\") begin
         phase = PH_STR_ESC;
      end else if (c == "\"") begin
         in_str = 0;
         phase = PH_NORMAL;
      end
   endfunction

   function automatic void ident_text_char(logic [20:0] c);
      style_type cls;
      if (is_letter(c) || is_digit(c) || c == "_") begin
         if (ident_len >= MAX_LINE) begin
            // overlong identifier: commit the first part as plain
            add_chars(ST_PLAIN, ident_len);
            ident_len = 1;
            phase = PH_IDENT_LONG;
         end else begin
            if (ident_len < PREFIX_DEPTH) begin
               word = {word, " "};
               word.putc(word.len() - 1, c[7:0]);
            end
            ident_len++;
         end
         return;
      end
      cls = word_style();
      if (cls != ST_PLAIN) begin
         add_chars(cls, ident_len);
         plain_text_char(c);
      end else if (is_space(c)) begin
         space_cnt = 1;
         phase = PH_SPACES;
      end else begin
         add_chars(c == "(" ? ST_FUNCTION : ST_PLAIN, ident_len);
         plain_text_char(c);
      end
   endfunction

   function automatic void line_end();
      logic [5:0] les;
      case (phase)
         PH_SLASH: add_chars(ST_PLAIN, 1);
         PH_IDENT, PH_IDENT_LONG: add_chars(word_style(), ident_len);
         PH_SPACES: begin
            add_chars(ST_PLAIN, ident_len);
            add_chars(ST_PLAIN, space_cnt);
         end
         PH_STR_ESC: in_gap = 1;
         default: ;
      endcase
      les = {in_gap, in_str, nest_depth};
      push_run(held_cnt > 0 ? held_style : ST_PLAIN, held_cnt, les, 1'b1);
      held_cnt = 0;
      held_style = ST_PLAIN;
      ident_len = 0;
      space_cnt = 0;
      if (nest_depth != 0) phase = PH_COMMENT;
      else if (in_gap) phase = PH_STR_GAP;
      else if (in_str) phase = PH_STR;
      else phase = PH_NORMAL;
   endfunction

   function automatic void predict_runs(lex_item_type it);
      runs_this_item = 0;
      if (it.eol) begin
         line_end();
         return;
      end
      case (phase)
         PH_SLASH:
            if (it.ch == "*") begin
               add_chars(ST_COMMENT, 2);
               nest_depth = 1;
               phase = PH_COMMENT;
            end else begin
               add_chars(ST_PLAIN, 1);
               plain_text_char(it.ch);
            end
         PH_IDENT, PH_IDENT_LONG: ident_text_char(it.ch);
         PH_SPACES:
            if (is_space(it.ch) && space_cnt < MAX_LINE) begin
               space_cnt++;
            end else begin
               add_chars(it.ch == "(" ? ST_FUNCTION : ST_PLAIN, ident_len);
               add_chars(ST_PLAIN, space_cnt);
               space_cnt = 0;
               plain_text_char(it.ch);
            end
         PH_COMMENT, PH_COMMENT_STAR, PH_COMMENT_SLASH: comment_text_char(it.ch);
         PH_STR, PH_STR_ESC, PH_STR_GAP: string_text_char(it.ch);
         default: plain_text_char(it.ch);
      endcase
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         stim.push_back('{eol: 0, ch: 21'(s[i]), typed: 0, want: '0});
   endfunction

   function automatic void add_eol();
      stim.push_back('{eol: 1, ch: 21'($urandom), typed: 0, want: '0});
   endfunction

   function automatic void add_repeat(string s, int n);
      repeat (n) add_text(s);
   endfunction

   // random lines built from tiger tokens, with some noise mixed in
   function automatic void add_random_line();
      int ntok;
      string id;
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
         case ($urandom_range(14))
            0: add_text(keywords[$urandom_range(16)]);
            1: add_text(type_names[$urandom_range(1)]);
            2: begin
               id = "";
               id = {id, string'(byte'($urandom_range(0, 1) ? "a" + $urandom_range(25)
                                                           : "A" + $urandom_range(25)))};
               repeat ($urandom_range(0, 10))
                  id = {id, string'(byte'($urandom_range(0, 3) == 0 ? "_" :
                                          $urandom_range(0, 1) ? "0" + $urandom_range(9)
                                                               : "a" + $urandom_range(25)))};
               add_text(id);
            end
            3: add_text("(");
            4: repeat ($urandom_range(1, 3))
                  add_text(string'(byte'($urandom_range(0, 2) != 0 ? " "
                                         : 9 + $urandom_range(4))));
            5: add_text("12");
            6: add_text("/*");
            7: add_text("*/");
            8: add_text("\"");
            9: add_text("\\ ");
            10: add_text("\\");
            11: stim.push_back('{eol: 0, ch: 21'($urandom), typed: 0, want: '0});
            12: add_text(") ;");
            13: if ($urandom_range(9) == 0) add_repeat("/*", 17);
                else add_text("x /");
            default: add_text("*");
         endcase
      end
      add_eol();
   endfunction

   task automatic drive_items();
      lex_item_type it;
      while (stim.size() > 0) begin
         it = stim.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= {3'b000, it.ch};
         req_tuser <= it.eol;
         do @(posedge clock); while (!req_tready);
         // transaction accepted at this edge
         if (it.typed) begin
            predict_runs(it);
            void'(runs_due.pop_back());
            runs_due.push_back(it.want);
         end else begin
            predict_runs(it);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type exp_run;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (runs_due.size() == 0) begin
            $error("unexpected run: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            failed = 1'b1;
         end else begin
            exp_run = runs_due.pop_front();
            if (rsp_tdata[2:0] != exp_run.style) begin
               $error("style: expected %0d actual %0d", exp_run.style, rsp_tdata[2:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[15:3] != exp_run.run_length) begin
               $error("run_length: expected %0d actual %0d", exp_run.run_length,
                      rsp_tdata[15:3]);
               failed = 1'b1;
            end
            if (rsp_tdata[21:16] != exp_run.line_end_state) begin
               $error("line_end_state: expected %h actual %h", exp_run.line_end_state,
                      rsp_tdata[21:16]);
               failed = 1'b1;
            end
            if (rsp_tlast != exp_run.last) begin
               $error("last: expected %b actual %b", exp_run.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tiger_syntax_highlight_lexer_core test failed");
         $finish;
      end
   end

   initial begin
      int target;
      nest_depth = 0; in_str = 0; in_gap = 0; phase = PH_NORMAL; word = "";
      ident_len = 0; space_cnt = 0; held_cnt = 0; held_style = ST_PLAIN;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty line, extreme code point, keywords, comments, strings
      stim.push_back('{eol: 1, ch: '0, typed: 1,
                       want: '{style: ST_PLAIN, run_length: 0, line_end_state: 0, last: 1}});
      stim.push_back('{eol: 0, ch: 21'h1FFFFF, typed: 0, want: '0});
      stim.push_back('{eol: 1, ch: 21'h1FFFFF, typed: 1,
                       want: '{style: ST_PLAIN, run_length: 1, line_end_state: 0, last: 1}});
      add_text("let f  (int)9/"); add_eol();
      add_text("/* a /**/"); add_eol();
      add_text("*/ \"s\\n\\ "); add_eol();
      add_text("  \\x\\"); add_eol();
      add_text("a\"end"); add_eol();
      drive_items();

      // random phases: no idling, sender idle, receiver stalls, both
      for (int p = 0; p < 4; p++) begin
         idle_pct = (p == 1) ? 46 : (p == 3) ? 10 : 0;
         stall_pct = (p == 2) ? 46 : (p == 3) ? 10 : 0;
         if (p == 0) hold_left = 300;
         target = RANDOM_ITEMS / 4;
         while (stim.size() < target) add_random_line();
         drive_items();
      end

      // overlong identifier, overlong whitespace, keyword before spaces and a paren, overlong run
      idle_pct = 0;
      stall_pct = 20;
      add_repeat("a", MAX_LINE + 5); add_eol();
      add_text("ab"); add_repeat(" ", MAX_LINE + 3); add_text("("); add_eol();
      add_text("if"); add_repeat(" ", 5); add_text("("); add_eol();
      add_repeat("=", MAX_LINE + 2); add_eol();
      drive_items();

      while (runs_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("tiger_syntax_highlight_lexer_core test passed");
      end else begin
         $display("tiger_syntax_highlight_lexer_core test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/tshl_pkg.sv
sv/tshl_step.sv
sv/tiger_syntax_highlight_lexer_core.sv
tb/tiger_syntax_highlight_lexer_core_test.sv
